@@ hdl/sarq_pkg.sv @@
`default_nettype none

package sarq_pkg;

    // Field widths of one beat.
    localparam int DIR_W  = 32;
    localparam int QUAT_W = 16;

    // Fixed-point constants.
    localparam logic [30:0] NEAR_ONE_Q30 = 31'd1073634450;
    localparam logic [31:0] Q30_ONE      = 32'd1073741824;
    localparam logic [14:0] Q14_ONE      = 15'd16384;

    // Reported case codes.
    typedef logic [1:0] t_case;
    localparam t_case CASE_GENERAL = 2'd0;
    localparam t_case CASE_ZERO    = 2'd1;
    localparam t_case CASE_ALIGNED = 2'd2;
    localparam t_case CASE_HALF    = 2'd3;

endpackage

`default_nettype wire

@@ hdl/sarq_isqrt.sv @@
`default_nettype none

// Pipelined integer square root, one root bit per stage.
module sarq_isqrt #(
    parameter int N  = 32,
    parameter int TW = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [2*N-1:0]  i_rad,
    input  wire logic [TW-1:0]   i_tag,
    output logic                 o_valid,
    output logic [N-1:0]         o_root,
    output logic [TW-1:0]        o_tag
);

    logic             r_vld [0:N-1];
    logic [N:0]       r_rem [0:N-1];
    logic [N-1:0]     r_root[0:N-1];
    logic [2*N-1:0]   r_rad [0:N-1];
    logic [TW-1:0]    r_tag [0:N-1];

    logic             c_vld [0:N-1];
    logic [N:0]       c_rem [0:N-1];
    logic [N-1:0]     c_root[0:N-1];
    logic [2*N-1:0]   c_rad [0:N-1];
    logic [TW-1:0]    c_tag [0:N-1];

    logic [N:0]       n_rem [0:N-1];
    logic [N-1:0]     n_root[0:N-1];

    // Stage inputs: the first stage takes the port, the rest take the previous stage.
    always_comb begin
        c_vld[0]  = i_valid;
        c_rem[0]  = '0;
        c_root[0] = '0;
        c_rad[0]  = i_rad;
        c_tag[0]  = i_tag;
        for (int k = 1; k < N; k++) begin
            c_vld[k]  = r_vld[k-1];
            c_rem[k]  = r_rem[k-1];
            c_root[k] = r_root[k-1];
            c_rad[k]  = r_rad[k-1];
            c_tag[k]  = r_tag[k-1];
        end
    end

    // One restoring step per stage: bring down two radicand bits and try root*4+1.
    always_comb begin
        logic [N+2:0] r2;
        logic [N+2:0] trial;
        for (int k = 0; k < N; k++) begin
            r2    = {c_rem[k], c_rad[k][2*N-1 -: 2]};
            trial = (N+3)'({c_root[k], 2'b01});
            if (r2 >= trial) begin
                n_rem[k]  = (N+1)'(r2 - trial);
                n_root[k] = {c_root[k][N-2:0], 1'b1};
            end else begin
                n_rem[k]  = (N+1)'(r2);
                n_root[k] = {c_root[k][N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= c_vld[k];
            end
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
            r_rad[k]  <= c_rad[k] << 2;
            r_tag[k]  <= c_tag[k];
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1];
    assign o_tag   = r_tag[N-1];

endmodule

`default_nettype wire

@@ hdl/sarq_div.sv @@
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// The starting remainder must be below the divisor.
module sarq_div #(
    parameter int DW = 32,
    parameter int QW = 31,
    parameter int TW = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [DW-1:0]  i_rem,
    input  wire logic [QW-1:0]  i_num,
    input  wire logic [DW-1:0]  i_den,
    input  wire logic [TW-1:0]  i_tag,
    output logic                o_valid,
    output logic [QW-1:0]       o_quo,
    output logic [TW-1:0]       o_tag
);

    logic            r_vld[0:QW-1];
    logic [DW-1:0]   r_rem[0:QW-1];
    logic [QW-1:0]   r_num[0:QW-1];
    logic [QW-1:0]   r_quo[0:QW-1];
    logic [DW-1:0]   r_den[0:QW-1];
    logic [TW-1:0]   r_tag[0:QW-1];

    logic            c_vld[0:QW-1];
    logic [DW-1:0]   c_rem[0:QW-1];
    logic [QW-1:0]   c_num[0:QW-1];
    logic [QW-1:0]   c_quo[0:QW-1];
    logic [DW-1:0]   c_den[0:QW-1];
    logic [TW-1:0]   c_tag[0:QW-1];

    logic [DW-1:0]   n_rem[0:QW-1];
    logic [QW-1:0]   n_quo[0:QW-1];

    // Stage inputs.
    always_comb begin
        c_vld[0] = i_valid;
        c_rem[0] = i_rem;
        c_num[0] = i_num;
        c_quo[0] = '0;
        c_den[0] = i_den;
        c_tag[0] = i_tag;
        for (int k = 1; k < QW; k++) begin
            c_vld[k] = r_vld[k-1];
            c_rem[k] = r_rem[k-1];
            c_num[k] = r_num[k-1];
            c_quo[k] = r_quo[k-1];
            c_den[k] = r_den[k-1];
            c_tag[k] = r_tag[k-1];
        end
    end

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        logic [DW:0] r2;
        logic        ge;
        for (int k = 0; k < QW; k++) begin
            r2       = {c_rem[k], c_num[k][QW-1]};
            ge       = (r2 >= {1'b0, c_den[k]});
            n_rem[k] = ge ? DW'(r2 - {1'b0, c_den[k]}) : DW'(r2);
            n_quo[k] = {c_quo[k][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= c_vld[k];
            end
            r_rem[k] <= n_rem[k];
            r_num[k] <= c_num[k] << 1;
            r_quo[k] <= n_quo[k];
            r_den[k] <= c_den[k];
            r_tag[k] <= c_tag[k];
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule

`default_nettype wire

@@ hdl/shortest_arc_quaternion_from_x_top.sv @@
`default_nettype none

// Shortest-arc quaternion from +X. Give a direction (signed Q16.16) with start;
// o_valid is later high for exactly one cycle with the unit
// quaternion (signed Q1.14) that turns +X onto it and the case taken. The
// pipeline takes a beat every cycle, so busy is always low, and results must
// be captured when o_valid is high since the receiver cannot stall. The
// pipeline is built from two bit-per-stage square roots (32 stages each), the
// 31-stage normalizing divider and the 15-stage ratio divider, plus staging
// registers for magnitudes, squares, length, case, ratio setup and output.
module shortest_arc_quaternion_from_x_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [31:0]          i_dir_x,
    input  wire logic signed [31:0]          i_dir_y,
    input  wire logic signed [31:0]          i_dir_z,
    output logic                             o_valid,
    output logic signed [15:0]               o_quat_w,
    output logic signed [15:0]               o_quat_x,
    output logic signed [15:0]               o_quat_y,
    output logic signed [15:0]               o_quat_z,
    output sarq_pkg::t_case                  o_case_taken
);

    import sarq_pkg::*;

    // Stage 1: signs and magnitudes.
    logic        r_vld1;
    logic        r_sx1, r_sy1, r_sz1;
    logic [31:0] r_ax1, r_ay1, r_az1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= start;
        end
        r_sx1 <= i_dir_x[31];
        r_sy1 <= i_dir_y[31];
        r_sz1 <= i_dir_z[31];
        r_ax1 <= i_dir_x[31] ? (~i_dir_x + 32'd1) : i_dir_x;
        r_ay1 <= i_dir_y[31] ? (~i_dir_y + 32'd1) : i_dir_y;
        r_az1 <= i_dir_z[31] ? (~i_dir_z + 32'd1) : i_dir_z;
    end

    // Stage 2: squares.
    logic        r_vld2;
    logic        r_sx2, r_sy2, r_sz2;
    logic [31:0] r_ax2, r_ay2, r_az2;
    logic [63:0] r_px2, r_py2, r_pz2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
        r_sx2 <= r_sx1;
        r_sy2 <= r_sy1;
        r_sz2 <= r_sz1;
        r_ax2 <= r_ax1;
        r_ay2 <= r_ay1;
        r_az2 <= r_az1;
        r_px2 <= 64'(r_ax1) * 64'(r_ax1);
        r_py2 <= 64'(r_ay1) * 64'(r_ay1);
        r_pz2 <= 64'(r_az1) * 64'(r_az1);
    end

    // Stage 3: squared length; it never exceeds 3 * 2^62.
    logic        r_vld3;
    logic        r_sx3, r_sy3, r_sz3;
    logic [31:0] r_ax3, r_ay3, r_az3;
    logic [63:0] r_lsq3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else begin
            r_vld3 <= r_vld2;
        end
        r_sx3  <= r_sx2;
        r_sy3  <= r_sy2;
        r_sz3  <= r_sz2;
        r_ax3  <= r_ax2;
        r_ay3  <= r_ay2;
        r_az3  <= r_az2;
        r_lsq3 <= r_px2 + r_py2 + r_pz2;
    end

    // Length by square root; the components ride along as tag.
    localparam int LT_W = 100;
    logic              len_vld;
    logic [31:0]       len;
    logic [LT_W-1:0]   len_tag;
    logic              len_zero;
    logic              len_sx, len_sy, len_sz;
    logic [31:0]       len_ax, len_ay, len_az;

    sarq_isqrt #(
        .N  (32),
        .TW (LT_W)
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld3),
        .i_rad   (r_lsq3),
        .i_tag   ({r_lsq3 == 64'd0, r_sx3, r_sy3, r_sz3, r_ax3, r_ay3, r_az3}),
        .o_valid (len_vld),
        .o_root  (len),
        .o_tag   (len_tag)
    );

    assign {len_zero, len_sx, len_sy, len_sz, len_ax, len_ay, len_az} = len_tag;

    // Normalize each component: |c| * 2^30 / len, at most 2^30.
    logic        ux_vld, uy_vld, uz_vld;
    logic [30:0] ux_q, uy_q, uz_q;
    logic [1:0]  ux_tag;
    logic        uy_sgn, uz_sgn;

    sarq_div #(
        .DW (32),
        .QW (31),
        .TW (2)
    ) u_unit_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (len_vld),
        .i_rem   ({1'b0, len_ax[31:1]}),
        .i_num   ({len_ax[0], 30'd0}),
        .i_den   (len),
        .i_tag   ({len_zero, len_sx}),
        .o_valid (ux_vld),
        .o_quo   (ux_q),
        .o_tag   (ux_tag)
    );

    sarq_div #(
        .DW (32),
        .QW (31),
        .TW (1)
    ) u_unit_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (len_vld),
        .i_rem   ({1'b0, len_ay[31:1]}),
        .i_num   ({len_ay[0], 30'd0}),
        .i_den   (len),
        .i_tag   (len_sy),
        .o_valid (uy_vld),
        .o_quo   (uy_q),
        .o_tag   (uy_sgn)
    );

    sarq_div #(
        .DW (32),
        .QW (31),
        .TW (1)
    ) u_unit_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (len_vld),
        .i_rem   ({1'b0, len_az[31:1]}),
        .i_num   ({len_az[0], 30'd0}),
        .i_den   (len),
        .i_tag   (len_sz),
        .o_valid (uz_vld),
        .o_quo   (uz_q),
        .o_tag   (uz_sgn)
    );

    // Case decision and s = 1 + d in Q1.30.
    logic        r_vldc;
    t_case       r_casec;
    logic        r_syc, r_szc;
    logic [30:0] r_tyc, r_tzc;
    logic [31:0] r_sc;
    t_case       n_casec;

    always_comb begin
        if (ux_tag[1]) begin
            n_casec = CASE_ZERO;
        end else if (ux_q > NEAR_ONE_Q30) begin
            n_casec = ux_tag[0] ? CASE_HALF : CASE_ALIGNED;
        end else begin
            n_casec = CASE_GENERAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldc <= 1'b0;
        end else begin
            r_vldc <= ux_vld & uy_vld & uz_vld;
        end
        r_casec <= n_casec;
        r_syc   <= uy_sgn;
        r_szc   <= uz_sgn;
        r_tyc   <= uy_q;
        r_tzc   <= uz_q;
        r_sc    <= ux_tag[0] ? (Q30_ONE - 32'(ux_q)) : (Q30_ONE + 32'(ux_q));
    end

    // W = floor(sqrt(s * 2^29)), w in Q0.30.
    localparam int WT_W = 66;
    logic            w_vld;
    logic [31:0]     w_root;
    logic [WT_W-1:0] w_tag;
    t_case           w_case;
    logic            w_sy, w_sz;
    logic [30:0]     w_ty, w_tz;

    sarq_isqrt #(
        .N  (32),
        .TW (WT_W)
    ) u_w_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vldc),
        .i_rad   (64'(r_sc) << 29),
        .i_tag   ({r_casec, r_syc, r_tyc, r_szc, r_tzc}),
        .o_valid (w_vld),
        .o_root  (w_root),
        .o_tag   (w_tag)
    );

    assign {w_case, w_sy, w_ty, w_sz, w_tz} = w_tag;

    // Ratio setup: quotient of (2*|t|*2^13 + W) by 2W, with a flag when it reaches 2^15.
    logic        r_vldr;
    t_case       r_caser;
    logic [14:0] r_wq14r;
    logic        r_syr, r_szr;
    logic        r_ovyr, r_ovzr;
    logic [45:0] r_nyr, r_nzr;
    logic [32:0] r_denr;
    logic [45:0] n_ny, n_nz;
    logic [32:0] n_den;
    logic [16:0] n_wq;

    always_comb begin
        n_ny  = {1'b0, w_tz, 14'd0} + 46'(w_root);
        n_nz  = {1'b0, w_ty, 14'd0} + 46'(w_root);
        n_den = {w_root, 1'b0};
        n_wq  = 17'((33'(w_root) + 33'd32768) >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldr <= 1'b0;
        end else begin
            r_vldr <= w_vld;
        end
        r_caser <= w_case;
        r_wq14r <= (n_wq > 17'(Q14_ONE)) ? Q14_ONE : 15'(n_wq);
        r_syr   <= w_sy;
        r_szr   <= w_sz;
        r_ovyr  <= (33'(n_ny[45:15]) >= n_den);
        r_ovzr  <= (33'(n_nz[45:15]) >= n_den);
        r_nyr   <= n_ny;
        r_nzr   <= n_nz;
        r_denr  <= n_den;
    end

    // Ratio dividers, 15 quotient bits each.
    localparam int RT_W = 19;
    logic            ry_vld, rz_vld;
    logic [14:0]     ry_q, rz_q;
    logic [RT_W-1:0] ry_tag;
    logic [1:0]      rz_tag;
    t_case           ry_case;
    logic [14:0]     ry_wq;
    logic            ry_ov, ry_sz, rz_ov, rz_sy;

    sarq_div #(
        .DW (33),
        .QW (15),
        .TW (RT_W)
    ) u_ratio_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vldr),
        .i_rem   (r_ovyr ? 33'd0 : 33'(r_nyr[45:15])),
        .i_num   (r_nyr[14:0]),
        .i_den   (r_denr),
        .i_tag   ({r_caser, r_wq14r, r_ovyr, r_szr}),
        .o_valid (ry_vld),
        .o_quo   (ry_q),
        .o_tag   (ry_tag)
    );

    sarq_div #(
        .DW (33),
        .QW (15),
        .TW (2)
    ) u_ratio_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vldr),
        .i_rem   (r_ovzr ? 33'd0 : 33'(r_nzr[45:15])),
        .i_num   (r_nzr[14:0]),
        .i_den   (r_denr),
        .i_tag   ({r_ovzr, r_syr}),
        .o_valid (rz_vld),
        .o_quo   (rz_q),
        .o_tag   (rz_tag)
    );

    assign {ry_case, ry_wq, ry_ov, ry_sz} = ry_tag;
    assign {rz_ov, rz_sy} = rz_tag;

    // Output stage: saturate, apply signs and the special cases.
    logic        r_vldo;
    t_case       r_caseo;
    logic [15:0] r_wo, r_yo, r_zo;
    logic [14:0] n_my, n_mz;
    logic [15:0] n_w, n_y, n_z;

    always_comb begin
        n_my = (ry_ov || ry_q > Q14_ONE) ? Q14_ONE : ry_q;
        n_mz = (rz_ov || rz_q > Q14_ONE) ? Q14_ONE : rz_q;
        unique case (ry_case)
            CASE_GENERAL: begin
                n_w = 16'(ry_wq);
                n_y = ry_sz ? 16'(n_my) : (16'd0 - 16'(n_my));
                n_z = rz_sy ? (16'd0 - 16'(n_mz)) : 16'(n_mz);
            end
            CASE_HALF: begin
                n_w = 16'd0;
                n_y = 16'd0;
                n_z = 16'(Q14_ONE);
            end
            default: begin
                n_w = 16'(Q14_ONE);
                n_y = 16'd0;
                n_z = 16'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldo <= 1'b0;
        end else begin
            r_vldo <= ry_vld & rz_vld;
        end
        r_caseo <= ry_case;
        r_wo    <= n_w;
        r_yo    <= n_y;
        r_zo    <= n_z;
    end

    assign busy         = 1'b0;
    assign o_valid      = r_vldo;
    assign o_quat_w     = r_wo;
    assign o_quat_x     = 16'sd0;
    assign o_quat_y     = r_yo;
    assign o_quat_z     = r_zo;
    assign o_case_taken = r_caseo;

endmodule

`default_nettype wire

@@ hdl/sarq_checker.sv @@
`default_nettype none

// Port-level checks for the shortest-arc quaternion block.
module sarq_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic               o_valid,
    input  wire logic signed [15:0] o_quat_w,
    input  wire logic signed [15:0] o_quat_x,
    input  wire logic signed [15:0] o_quat_y,
    input  wire logic signed [15:0] o_quat_z,
    input  wire sarq_pkg::t_case    o_case_taken
);

    import sarq_pkg::*;

    // The pipeline never refuses a beat.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> !busy)
        else $error("busy raised while the pipeline should take every beat");

    // Identity is reported for the zero vector and aligned directions.
    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_case_taken == CASE_ZERO || o_case_taken == CASE_ALIGNED)
        |-> o_quat_w == 16'sd16384 && o_quat_x == 16'sd0
            && o_quat_y == 16'sd0 && o_quat_z == 16'sd0)
        else $error("identity case with a non-identity quaternion");

    // The opposite case is a half turn about Z.
    a_half_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_case_taken == CASE_HALF
        |-> o_quat_w == 16'sd0 && o_quat_y == 16'sd0 && o_quat_z == 16'sd16384)
        else $error("half-turn case with a wrong quaternion");

    // General results keep w, y and z in range and x at zero.
    a_general_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_case_taken == CASE_GENERAL
        |-> o_quat_w >= 16'sd0 && o_quat_w <= 16'sd16384 && o_quat_x == 16'sd0
            && o_quat_y >= -16'sd16384 && o_quat_y <= 16'sd16384
            && o_quat_z >= -16'sd16384 && o_quat_z <= 16'sd16384)
        else $error("general result out of range");

endmodule

bind shortest_arc_quaternion_from_x_top sarq_checker u_sarq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_quat_w     (o_quat_w),
    .o_quat_x     (o_quat_x),
    .o_quat_y     (o_quat_y),
    .o_quat_z     (o_quat_z),
    .o_case_taken (o_case_taken)
);

`default_nettype wire
